/* rtl/tea_block_cipher_defines.svh */
// Assertion macros shared by the TEA cipher RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef TEA_BLOCK_CIPHER_DEFINES_SVH
`define TEA_BLOCK_CIPHER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Antecedent holds in a cycle, consequent must hold in the same cycle.
`define TEA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Antecedent holds in a cycle, consequent must hold in the next cycle.
`define TEA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TEA_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define TEA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

/* rtl/tea_pkg.sv */
// Constants and helper functions for the TEA block cipher.
// No dependencies; imported by the interfaces and the top level.
`timescale 1ns / 1ps

package tea_pkg;

  localparam int unsigned TEA_ROUNDS    = 32;
  localparam int unsigned TEA_STAGES    = 2 * TEA_ROUNDS;
  localparam int unsigned TEA_KEYS      = 4;
  localparam int unsigned TEA_KEY_IDX_W = 2;
  localparam int unsigned TEA_WORD_W    = 32;
  localparam int unsigned TEA_BLOCK_W   = 64;

  localparam logic [TEA_WORD_W-1:0] TEA_DELTA = 32'h9E37_79B9;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  localparam logic [TEA_KEY_IDX_W-1:0] KEY_IDX_0 = 2'd0;
  localparam logic [TEA_KEY_IDX_W-1:0] KEY_IDX_1 = 2'd1;
  localparam logic [TEA_KEY_IDX_W-1:0] KEY_IDX_2 = 2'd2;
  localparam logic [TEA_KEY_IDX_W-1:0] KEY_IDX_3 = 2'd3;

  typedef logic [TEA_WORD_W-1:0]  tea_word_t;
  typedef logic [TEA_BLOCK_W-1:0] tea_block_t;

  // Running sum after n additions of delta, modulo 2^32.
  function automatic tea_word_t tea_sum(input int unsigned n);
    logic [63:0] prod;
    prod = 64'(n) * 64'(TEA_DELTA);
    return prod[TEA_WORD_W-1:0];
  endfunction

  // TEA half-round mixing function.
  function automatic tea_word_t tea_mix(input tea_word_t v, input tea_word_t s,
                                        input tea_word_t ka, input tea_word_t kb);
    return ((v << 4) + ka) ^ (v + s) ^ ((v >> 5) + kb);
  endfunction

endpackage

/* rtl/tea_if.sv */
// Request and response channel interfaces of the TEA block cipher.
// Depends on tea_pkg for the payload types.
`timescale 1ns / 1ps

interface tea_req_if import tea_pkg::*;;
  logic       valid;
  logic       ready;
  logic       op;
  tea_block_t in_block;

  modport source (output valid, output op, output in_block, input ready);
  modport sink   (input valid, input op, input in_block, output ready);
endinterface

interface tea_rsp_if import tea_pkg::*;;
  logic       valid;
  logic       ready;
  tea_block_t out_block;

  modport source (output valid, output out_block, input ready);
  modport sink   (input valid, input out_block, output ready);
endinterface

/* rtl/tea_block_cipher.sv */
// Channel   | Direction | Payload                     | Handshake
// req       | in        | op (1), in_block (64)       | valid / ready
// rsp       | out       | out_block (64)              | valid / ready
// cfg       | in        | cfg_index (2), cfg_data(32) | cfg_we, no wait
//
// One request enters per cycle while the skid register is empty; each result
// comes out of the chain of 64 half-round stages (two per TEA round).
// Reset (rst, synchronous) clears key words, stage valid bits and skid_vld.
// A stall on rsp parks the last stage's result in a one-entry skid register;
// while that register is full the whole pipeline holds, so nothing is lost
// or repeated, and req.ready comes straight from a flop.
// Depends on tea_pkg, tea_if and tea_block_cipher_defines.svh.
`timescale 1ns / 1ps
`include "tea_block_cipher_defines.svh"

module tea_block_cipher import tea_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [TEA_KEY_IDX_W-1:0] cfg_index,
  input  tea_word_t                cfg_data,
  tea_req_if.sink                  req,
  tea_rsp_if.source                rsp
);

  // Key words, to be written only while the block is idle; the block does not enforce it.
  tea_word_t key_word_0;
  tea_word_t key_word_1;
  tea_word_t key_word_2;
  tea_word_t key_word_3;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_word_0 <= '0;
      key_word_1 <= '0;
      key_word_2 <= '0;
      key_word_3 <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        KEY_IDX_0: key_word_0 <= cfg_data;
        KEY_IDX_1: key_word_1 <= cfg_data;
        KEY_IDX_2: key_word_2 <= cfg_data;
        KEY_IDX_3: key_word_3 <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline registers. Stage s holds the block after half-round s.
  logic [TEA_STAGES-1:0] stage_vld;
  logic                  stage_op [TEA_STAGES];
  tea_word_t             stage_hi [TEA_STAGES];
  tea_word_t             stage_lo [TEA_STAGES];

  // Skid register behind the last stage.
  logic       skid_vld;
  tea_block_t skid_block;

  // The pipeline moves whenever the skid register is free.
  logic adv;
  assign adv       = !skid_vld;
  assign req.ready = adv;

  for (genvar s = 0; s < TEA_STAGES; s++) begin : g_stage
    localparam int unsigned RND     = s / 2;
    localparam bit          FIRST   = ((s % 2) == 0);
    localparam tea_word_t   ENC_SUM = tea_sum(RND + 1);
    localparam tea_word_t   DEC_SUM = tea_sum(TEA_ROUNDS - RND);

    logic      vld_in;
    logic      op_in;
    tea_word_t hi_in;
    tea_word_t lo_in;
    tea_word_t hi_out;
    tea_word_t lo_out;

    if (s == 0) begin : g_src_port
      assign vld_in = req.valid;
      assign op_in  = req.op;
      assign hi_in  = req.in_block[TEA_BLOCK_W-1:TEA_WORD_W];
      assign lo_in  = req.in_block[TEA_WORD_W-1:0];
    end else begin : g_src_stage
      assign vld_in = stage_vld[s-1];
      assign op_in  = stage_op[s-1];
      assign hi_in  = stage_hi[s-1];
      assign lo_in  = stage_lo[s-1];
    end

    // Encryption updates the high half first, then the low half; decryption
    // runs the same round backward, low half first.
    always_comb begin
      hi_out = hi_in;
      lo_out = lo_in;
      if (FIRST) begin
        if (op_in == OP_DECRYPT) begin
          lo_out = lo_in - tea_mix(hi_in, DEC_SUM, key_word_2, key_word_3);
        end else begin
          hi_out = hi_in + tea_mix(lo_in, ENC_SUM, key_word_0, key_word_1);
        end
      end else begin
        if (op_in == OP_DECRYPT) begin
          hi_out = hi_in - tea_mix(lo_in, DEC_SUM, key_word_0, key_word_1);
        end else begin
          lo_out = lo_in + tea_mix(hi_in, ENC_SUM, key_word_2, key_word_3);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stage_vld[s] <= 1'b0;
      end else if (adv) begin
        stage_vld[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        stage_op[s] <= op_in;
        stage_hi[s] <= hi_out;
        stage_lo[s] <= lo_out;
      end
    end
  end

  tea_block_t last_block;
  logic       last_vld;
  assign last_block = {stage_hi[TEA_STAGES-1], stage_lo[TEA_STAGES-1]};
  assign last_vld   = stage_vld[TEA_STAGES-1];

  // The skid register fills when a finished result is not taken while the
  // pipeline moves, and empties once the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_vld <= 1'b0;
    end else if (skid_vld) begin
      if (rsp.ready) begin
        skid_vld <= 1'b0;
      end
    end else if (last_vld && !rsp.ready) begin
      skid_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_vld) begin
      skid_block <= last_block;
    end
  end

  assign rsp.valid     = skid_vld || last_vld;
  assign rsp.out_block = skid_vld ? skid_block : last_block;

  `TEA_ASSERT_NEXT(a_accept_enters, clk, rst, req.valid && req.ready, stage_vld[0], "accepted request did not enter the first stage")
  `TEA_ASSERT_NEXT(a_skid_holds, clk, rst, skid_vld && !rsp.ready, skid_vld && $stable(skid_block), "parked result changed or was dropped")
  `TEA_ASSERT_NEXT(a_freeze, clk, rst, skid_vld, $stable(stage_vld), "pipeline moved while the skid register was full")
  `TEA_ASSERT_SAME(a_skid_behind_last, clk, rst, skid_vld && !$past(skid_vld), $past(last_vld), "skid register filled without a finished result")

endmodule

/* tb/tb.sv */
// Self-checking testbench for the pipelined TEA block cipher (tea_block_cipher).
// Depends on tea_pkg and the tea_req_if / tea_rsp_if channel interfaces of the RTL.
`timescale 1ns / 1ps

module tb;
  import tea_pkg::*;

  // One pending request: the operation, the block, and whether the sender
  // must wait for the pipeline to drain completely before presenting it.
  typedef struct {
    logic       op;
    tea_block_t blk;
    bit         drain_first;
  } block_request_t;

  logic                     clk;
  logic                     rst;
  logic                     cfg_we;
  logic [TEA_KEY_IDX_W-1:0] cfg_index;
  tea_word_t                cfg_data;

  tea_req_if req_ch ();
  tea_rsp_if rsp_ch ();

  tea_block_cipher dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // Requests waiting to be driven, and the blocks the cipher must return,
  // oldest first. The key copy mirrors the key registers inside the block.
  block_request_t request_queue[$];
  tea_block_t     expected_blocks[$];
  tea_word_t      key_copy[TEA_KEYS];
  int unsigned    error_count;

  // Idling enables (changed between phases only) and their gap and stall counters.
  bit          src_idle_on;
  bit          snk_stall_on;
  int unsigned src_gap;
  int unsigned snk_stall;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The limit allows every request its longest gap, every result its
  // longest stall and a full pipeline drain, several times over.
  initial begin
    #5_000_000;
    $display("tea_block_cipher regression: fail");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // The TEA round function applied to one half, with one pair of key words.
  function automatic tea_word_t feistel_f(input tea_word_t v, input tea_word_t s,
                                          input tea_word_t ka, input tea_word_t kb);
    return ((v << 4) + ka) ^ (v + s) ^ ((v >> 5) + kb);
  endfunction

  // Expected cipher output for one request under the current key copy.
  // The upper word of the block is the first half, the lower word the second.
  function automatic tea_block_t tea_expected(input logic op, input tea_block_t blk);
    tea_word_t hi;
    tea_word_t lo;
    tea_word_t sum;
    hi = blk[63:32];
    lo = blk[31:0];
    if (op == OP_ENCRYPT) begin
      sum = '0;
      for (int r = 0; r < TEA_ROUNDS; r++) begin
        sum = sum + TEA_DELTA;
        hi  = hi + feistel_f(lo, sum, key_copy[0], key_copy[1]);
        lo  = lo + feistel_f(hi, sum, key_copy[2], key_copy[3]);
      end
    end else begin
      // Decryption starts from the sum reached after the last encryption
      // round and walks it back down.
      sum = '0;
      for (int r = 0; r < TEA_ROUNDS; r++) begin
        sum = sum + TEA_DELTA;
      end
      for (int r = 0; r < TEA_ROUNDS; r++) begin
        lo  = lo - feistel_f(hi, sum, key_copy[2], key_copy[3]);
        hi  = hi - feistel_f(lo, sum, key_copy[0], key_copy[1]);
        sum = sum - TEA_DELTA;
      end
    end
    return {hi, lo};
  endfunction

  // Most gaps are short, some are a few cycles, and a few are long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic tea_word_t rand_key_word();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 2) begin
      return '0;
    end else if (r < 4) begin
      return '1;
    end
    return $urandom;
  endfunction

  // Random blocks lean on full random data but regularly hit the extremes,
  // half-zero and half-ones patterns, and single set bits.
  function automatic tea_block_t rand_block();
    case ($urandom_range(0, 9))
      6: begin
        return $urandom_range(0, 1) ? {32'h0, 32'($urandom)} : {32'($urandom), 32'h0};
      end
      7: begin
        return $urandom_range(0, 1) ? {32'hFFFF_FFFF, 32'($urandom)}
                                    : {32'($urandom), 32'hFFFF_FFFF};
      end
      8: begin
        return 64'd1 << $urandom_range(0, 63);
      end
      9: begin
        return $urandom_range(0, 1) ? '1 : '0;
      end
      default: begin
        return {32'($urandom), 32'($urandom)};
      end
    endcase
  endfunction

  task automatic queue_request(input logic op, input tea_block_t blk, input bit drain_first);
    block_request_t item;
    item.op          = op;
    item.blk         = blk;
    item.drain_first = drain_first;
    request_queue.push_back(item);
  endtask

  // One key register write; the caller lowers the write enable afterwards.
  task automatic write_key(input logic [TEA_KEY_IDX_W-1:0] idx, input tea_word_t value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    key_copy[idx] = value;
  endtask

  task automatic load_key_set(input tea_word_t k0, input tea_word_t k1,
                              input tea_word_t k2, input tea_word_t k3);
    write_key(KEY_IDX_0, k0);
    write_key(KEY_IDX_1, k1);
    write_key(KEY_IDX_2, k2);
    write_key(KEY_IDX_3, k3);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Idle means every queued request was accepted and every result returned.
  // Each request yields exactly one result, so no extra settling is needed.
  task automatic wait_idle();
    do begin
      @(posedge clk);
    end while (request_queue.size() != 0 || req_ch.valid || expected_blocks.size() != 0);
  endtask

  // Request driver. An accepted request is predicted at the edge where it
  // is taken, using the key copy, which only changes while the block idles.
  // After each request the driver may hold off for a random gap; a request
  // marked drain_first waits until no result is outstanding.
  always @(posedge clk) begin : request_driver
    logic src_busy;
    if (rst) begin
      req_ch.valid <= 1'b0;
      src_gap      <= 0;
    end else begin
      src_busy = req_ch.valid;
      if (req_ch.valid && req_ch.ready) begin
        expected_blocks.push_back(tea_expected(req_ch.op, req_ch.in_block));
        src_busy = 1'b0;
      end
      if (!src_busy) begin
        if (src_gap != 0) begin
          src_gap      <= src_gap - 1;
          req_ch.valid <= 1'b0;
        end else if (request_queue.size() != 0 &&
                     !(request_queue[0].drain_first && expected_blocks.size() != 0)) begin
          req_ch.valid    <= 1'b1;
          req_ch.op       <= request_queue[0].op;
          req_ch.in_block <= request_queue[0].blk;
          src_gap         <= src_idle_on ? pick_gap() : 0;
          void'(request_queue.pop_front());
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Every accepted block is compared with the oldest
  // expectation; ready drops for random stretches when stalling is enabled.
  always @(posedge clk) begin : result_monitor
    tea_block_t want_block;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      snk_stall    <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_blocks.size() == 0) begin
          report_mismatch($sformatf("unexpected out_block %h", rsp_ch.out_block));
        end else begin
          want_block = expected_blocks.pop_front();
          if (rsp_ch.out_block !== want_block) begin
            report_mismatch($sformatf("out_block %h, expected %h",
                                      rsp_ch.out_block, want_block));
          end
        end
      end
      if (snk_stall != 0) begin
        snk_stall    <= snk_stall - 1;
        rsp_ch.ready <= 1'b0;
      end else if (snk_stall_on && $urandom_range(0, 99) < 25) begin
        snk_stall    <= pick_gap();
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    tea_block_t plain;
    tea_block_t cipher;
    int         made;

    // Every input starts at a known value; reset then clears the keys.
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = KEY_IDX_0;
    cfg_data        = '0;
    req_ch.valid    = 1'b0;
    req_ch.op       = OP_ENCRYPT;
    req_ch.in_block = '0;
    rsp_ch.ready    = 1'b0;
    error_count     = 0;
    src_idle_on     = 1'b1;
    snk_stall_on    = 1'b1;
    for (int k = 0; k < TEA_KEYS; k++) begin
      key_copy[k] = '0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: the all-zero key left by reset, with extreme blocks.
    queue_request(OP_ENCRYPT, '0, 1'b0);
    queue_request(OP_DECRYPT, '0, 1'b0);
    queue_request(OP_ENCRYPT, '1, 1'b0);
    queue_request(OP_DECRYPT, '1, 1'b0);
    wait_idle();

    // Directed: the all-ones key.
    load_key_set('1, '1, '1, '1);
    queue_request(OP_ENCRYPT, '0, 1'b0);
    queue_request(OP_DECRYPT, '1, 1'b0);
    queue_request(OP_ENCRYPT, 64'h8000_0000_0000_0001, 1'b0);
    queue_request(OP_DECRYPT, 64'h0000_0001_8000_0000, 1'b0);
    wait_idle();

    // Directed: a mixed key, a round trip, opposite half extremes, and one
    // request that is held back until the pipeline has fully drained.
    load_key_set(32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210);
    plain  = 64'h0123_4567_89AB_CDEF;
    cipher = tea_expected(OP_ENCRYPT, plain);
    queue_request(OP_ENCRYPT, plain, 1'b0);
    queue_request(OP_DECRYPT, cipher, 1'b0);
    queue_request(OP_ENCRYPT, 64'hFFFF_FFFF_0000_0000, 1'b0);
    queue_request(OP_ENCRYPT, 64'h0000_0000_FFFF_FFFF, 1'b0);
    queue_request(OP_DECRYPT, 64'hAAAA_AAAA_5555_5555, 1'b0);
    queue_request(OP_ENCRYPT, 64'h5555_5555_AAAA_AAAA, 1'b0);
    queue_request(OP_DECRYPT, 64'h0F1E_2D3C_4B5A_6978, 1'b1);
    queue_request(OP_ENCRYPT, 64'h8000_0000_0000_0000, 1'b0);
    queue_request(OP_DECRYPT, 64'h0000_0000_0000_0001, 1'b0);
    queue_request(OP_ENCRYPT, 64'h0000_0001_0000_0000, 1'b0);
    queue_request(OP_DECRYPT, 64'h0000_0000_8000_0000, 1'b0);
    queue_request(OP_ENCRYPT, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    wait_idle();

    // Random phases, each with its own key set. Phase two runs with no
    // idling on either side, phase three only idles the sender and phase
    // four only stalls the receiver. Most traffic is round trips, whose
    // second half must restore the first half's block.
    for (int phase = 0; phase < 6; phase++) begin
      src_idle_on  = (phase != 2 && phase != 4);
      snk_stall_on = (phase != 2 && phase != 3);
      load_key_set(rand_key_word(), rand_key_word(), rand_key_word(), rand_key_word());
      made = 0;
      while (made < 88) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            plain = rand_block();
            queue_request(OP_ENCRYPT, plain, 1'b0);
            queue_request(OP_DECRYPT, tea_expected(OP_ENCRYPT, plain), 1'b0);
            made += 2;
          end
          4: begin
            cipher = rand_block();
            queue_request(OP_DECRYPT, cipher, 1'b0);
            queue_request(OP_ENCRYPT, tea_expected(OP_DECRYPT, cipher), 1'b0);
            made += 2;
          end
          default: begin
            queue_request($urandom_range(0, 1) ? OP_DECRYPT : OP_ENCRYPT, rand_block(),
                          $urandom_range(0, 99) < 2);
            made += 1;
          end
        endcase
      end
      wait_idle();
    end

    // Keep clocking the idle pipeline so that any stray result shows up.
    repeat (2 * TEA_STAGES) @(posedge clk);
    if (error_count == 0) begin
      $display("tea_block_cipher regression: pass");
    end else begin
      $display("tea_block_cipher regression: fail");
    end
    $finish;
  end

endmodule
